@@ design/bplm_pkg.sv @@
package bplm_pkg;

	// Fixed field widths of the request and response
	localparam int BLK_W   = 24;
	localparam int PIN_W   = 8;
	localparam int STAT_W  = 3;
	localparam int FRAME_W = 4;

	// Default frame count
	localparam int NUM_FRAMES_DEF = 16;

	// Response status codes
	typedef enum logic [STAT_W-1:0] {
		ST_HIT     = 3'd0,
		ST_LOAD    = 3'd1,
		ST_EVICT   = 3'd2,
		ST_NOFRAME = 3'd3,
		ST_UNPIN   = 3'd4,
		ST_NOTRES  = 3'd5,
		ST_NOTPIN  = 3'd6
	} status_t;

	// Request opcodes
	localparam logic OP_PIN   = 1'b0;
	localparam logic OP_UNPIN = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture request, restart scan
		logic scan;    // issue a lookup read
		logic fix;     // issue a rank fix-up read
		logic commit;  // write the chosen frame, load the response
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic idx_last;  // frame counter at the last frame
		logic need_fix;  // a frame leaves the LRU list
	} sts_t;

endpackage

@@ design/bplm_req_if.sv @@
interface bplm_req_if;
	import bplm_pkg::*;

	logic             valid;
	logic             ready;
	logic             op;
	logic [BLK_W-1:0] block_id;
	logic             mark_dirty;

	modport source (output valid, output op, output block_id, output mark_dirty, input ready);
	modport sink (input valid, input op, input block_id, input mark_dirty, output ready);

endinterface

@@ design/bplm_rsp_if.sv @@
interface bplm_rsp_if;
	import bplm_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [FRAME_W-1:0] frame;
	logic               writeback;
	logic [BLK_W-1:0]   old_block;
	logic [PIN_W-1:0]   pins_after;

	modport source (output valid, output status, output frame, output writeback,
		output old_block, output pins_after, input ready);
	modport sink (input valid, input status, input frame, input writeback,
		input old_block, input pins_after, output ready);

endinterface

@@ design/bplm_ram.sv @@
module bplm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/bplm_ctrl.sv @@
module bplm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bplm_pkg::cmd_t cmd,
	input  bplm_pkg::sts_t sts
);
	import bplm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_FIX,
		S_FIX_END,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_vld_q;

	// Commands decoded from state
	always_comb begin
		req_ready  = (state_q == S_IDLE);
		rsp_valid  = out_vld_q;
		cmd.load   = (state_q == S_IDLE) && req_valid;
		cmd.scan   = (state_q == S_SCAN);
		cmd.fix    = (state_q == S_FIX);
		cmd.commit = (state_q == S_COMMIT) && (!out_vld_q || rsp_ready);
	end

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.idx_last) state_q <= S_SCAN_END;
				end
				S_SCAN_END: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= sts.need_fix ? S_FIX : S_COMMIT;
				end
				S_FIX: begin
					if (sts.idx_last) state_q <= S_FIX_END;
				end
				S_FIX_END: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/bplm_dp.sv @@
module bplm_dp #(
	parameter int NUM_FRAMES = bplm_pkg::NUM_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bplm_pkg::cmd_t                cmd,
	output bplm_pkg::sts_t                sts,
	input  logic                          req_op,
	input  logic [bplm_pkg::BLK_W-1:0]    req_block_id,
	input  logic                          req_mark_dirty,
	output logic [bplm_pkg::STAT_W-1:0]   rsp_status,
	output logic [bplm_pkg::FRAME_W-1:0]  rsp_frame,
	output logic                          rsp_writeback,
	output logic [bplm_pkg::BLK_W-1:0]    rsp_old_block,
	output logic [bplm_pkg::PIN_W-1:0]    rsp_pins_after
);
	import bplm_pkg::*;

	localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int TW    = $clog2(NUM_FRAMES + 1);
	// Frame word layout: {block, pins, dirty, rank}
	localparam int DT_BIT = FW;
	localparam int PN_LO  = FW + 1;
	localparam int BK_LO  = FW + 1 + PIN_W;
	localparam int DW     = BK_LO + BLK_W;

	// Request registers
	logic             op_q;
	logic [BLK_W-1:0] blk_q;
	logic             md_q;

	// Frame counter and read pipeline
	logic [FW-1:0] idx_q;
	logic          rd_scan_s1;
	logic          rd_fix_s1;
	logic [FW-1:0] rd_idx_s1;
	logic [DW-1:0] rd_word;
	logic [BLK_W-1:0] d_blk;
	logic [PIN_W-1:0] d_pins;
	logic             d_dirty;
	logic [FW-1:0]    d_rank;
	logic             d_vld;

	// Frame valid bits and LRU list length
	logic [NUM_FRAMES-1:0] valid_q;
	logic [TW-1:0]         total_q;

	// Scan results
	logic             hit_fnd_q;
	logic [FW-1:0]    hit_idx_q;
	logic [PIN_W-1:0] hit_pins_q;
	logic             hit_dirty_q;
	logic [FW-1:0]    hit_rank_q;
	logic             free_fnd_q;
	logic [FW-1:0]    free_idx_q;
	logic             old_fnd_q;
	logic [FW-1:0]    old_idx_q;
	logic [BLK_W-1:0] old_blk_q;
	logic             old_dirty_q;

	// Decision
	status_t          dec_status;
	logic [FW-1:0]    dec_frame;
	logic             dec_wb;
	logic [BLK_W-1:0] dec_old;
	logic [PIN_W-1:0] dec_pins;
	logic             dec_fix;
	logic [FW-1:0]    dec_rm_rank;
	logic             dec_wr;
	logic             dec_dirty;
	logic [FW-1:0]    dec_rank;
	logic             dec_set_vld;
	logic             dec_inc;
	logic [PIN_W-1:0] pin_up;
	logic [PIN_W-1:0] pin_dn;

	// RAM ports
	logic          ram_we;
	logic [FW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          fix_wr;

	// Response registers
	status_t          res_status_q;
	logic [FW-1:0]    res_frame_q;
	logic             res_wb_q;
	logic [BLK_W-1:0] res_old_q;
	logic [PIN_W-1:0] res_pins_q;

	bplm_ram #(
		.WIDTH (DW),
		.DEPTH (NUM_FRAMES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (rd_word)
	);

	// Fields of the frame word that just came out of the RAM
	always_comb begin
		d_blk   = rd_word[BK_LO +: BLK_W];
		d_pins  = rd_word[PN_LO +: PIN_W];
		d_dirty = rd_word[DT_BIT];
		d_rank  = rd_word[FW-1:0];
		d_vld   = valid_q[rd_idx_s1];
	end

	assign sts.idx_last = (idx_q == FW'(NUM_FRAMES - 1));
	assign sts.need_fix = dec_fix;

	// Choose the outcome from the scan results
	always_comb begin
		pin_up      = (hit_pins_q == '1) ? hit_pins_q : hit_pins_q + 1'b1;
		pin_dn      = hit_pins_q - 1'b1;
		dec_status  = ST_NOFRAME;
		dec_frame   = '0;
		dec_wb      = 1'b0;
		dec_old     = '0;
		dec_pins    = '0;
		dec_fix     = 1'b0;
		dec_rm_rank = '0;
		dec_wr      = 1'b0;
		dec_dirty   = 1'b0;
		dec_rank    = '0;
		dec_set_vld = 1'b0;
		dec_inc     = 1'b0;
		if (op_q == OP_PIN) begin
			if (hit_fnd_q) begin
				dec_status  = ST_HIT;
				dec_frame   = hit_idx_q;
				dec_pins    = pin_up;
				dec_fix     = (hit_pins_q == '0);
				dec_rm_rank = hit_rank_q;
				dec_wr      = 1'b1;
				dec_dirty   = hit_dirty_q;
				dec_rank    = hit_rank_q;
			end else if (free_fnd_q) begin
				dec_status  = ST_LOAD;
				dec_frame   = free_idx_q;
				dec_pins    = PIN_W'(1);
				dec_wr      = 1'b1;
				dec_set_vld = 1'b1;
			end else if (old_fnd_q) begin
				// oldest frame has rank zero, every other list member moves down
				dec_status = ST_EVICT;
				dec_frame  = old_idx_q;
				dec_wb     = old_dirty_q;
				dec_old    = old_blk_q;
				dec_pins   = PIN_W'(1);
				dec_fix    = 1'b1;
				dec_wr     = 1'b1;
			end
		end else begin
			if (!hit_fnd_q) begin
				dec_status = ST_NOTRES;
			end else if (hit_pins_q == '0) begin
				dec_status = ST_NOTPIN;
				dec_frame  = hit_idx_q;
			end else begin
				dec_status = ST_UNPIN;
				dec_frame  = hit_idx_q;
				dec_pins   = pin_dn;
				dec_wr     = 1'b1;
				dec_dirty  = hit_dirty_q | md_q;
				dec_inc    = (pin_dn == '0);
				// joins the list as the most recent member
				dec_rank   = (pin_dn == '0) ? FW'(total_q) : hit_rank_q;
			end
		end
	end

	// RAM write: rank fix-up during the second pass, frame update on commit
	always_comb begin
		fix_wr = rd_fix_s1 && d_vld && (d_pins == '0) && (d_rank > dec_rm_rank)
			&& (rd_idx_s1 != dec_frame);
		ram_we = fix_wr || (cmd.commit && dec_wr);
		if (cmd.commit) begin
			ram_waddr = dec_frame;
			ram_wdata = {blk_q, dec_pins, dec_dirty, dec_rank};
		end else begin
			ram_waddr = rd_idx_s1;
			ram_wdata = {rd_word[DW-1:FW], d_rank - 1'b1};
		end
	end

	// Frame counter and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rd_scan_s1 <= 1'b0;
			rd_fix_s1  <= 1'b0;
		end else begin
			rd_scan_s1 <= cmd.scan;
			rd_fix_s1  <= cmd.fix;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan || cmd.fix) begin
				idx_q <= sts.idx_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_op;
			blk_q <= req_block_id;
			md_q  <= req_mark_dirty;
		end
	end

	// Scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
			old_fnd_q  <= 1'b0;
		end else if (cmd.load) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
			old_fnd_q  <= 1'b0;
		end else if (rd_scan_s1) begin
			if (d_vld && (d_blk == blk_q)) hit_fnd_q <= 1'b1;
			if (!d_vld) free_fnd_q <= 1'b1;
			if (d_vld && (d_pins == '0) && (d_rank == '0)) old_fnd_q <= 1'b1;
		end
	end

	// Scan payload: lowest matching frame wins
	always_ff @(posedge clk) begin
		if (rd_scan_s1 && !cmd.load) begin
			if (!hit_fnd_q && d_vld && (d_blk == blk_q)) begin
				hit_idx_q   <= rd_idx_s1;
				hit_pins_q  <= d_pins;
				hit_dirty_q <= d_dirty;
				hit_rank_q  <= d_rank;
			end
			if (!free_fnd_q && !d_vld) begin
				free_idx_q <= rd_idx_s1;
			end
			if (!old_fnd_q && d_vld && (d_pins == '0) && (d_rank == '0)) begin
				old_idx_q   <= rd_idx_s1;
				old_blk_q   <= d_blk;
				old_dirty_q <= d_dirty;
			end
		end
	end

	// Valid bits and list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (cmd.commit) begin
			if (dec_set_vld) valid_q[dec_frame] <= 1'b1;
			if (dec_fix && (total_q != '0)) begin
				total_q <= total_q - 1'b1;
			end else if (dec_inc) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status_q <= dec_status;
			res_frame_q  <= dec_frame;
			res_wb_q     <= dec_wb;
			res_old_q    <= dec_old;
			res_pins_q   <= dec_pins;
		end
	end

	assign rsp_status     = res_status_q;
	assign rsp_frame      = FRAME_W'(res_frame_q);
	assign rsp_writeback  = res_wb_q;
	assign rsp_old_block  = res_old_q;
	assign rsp_pins_after = res_pins_q;

endmodule

@@ design/buffer_pool_lru_pin_manager.sv @@
// Channel  Dir  Payload                                              Handshake
// req      in   op, block_id[23:0], mark_dirty                       valid/ready
// rsp      out  status[2:0], frame[3:0], writeback, old_block[23:0],  valid/ready
//               pins_after[7:0]
//
// Each request runs a lookup pass over all frames, then a decide step, a rank
// fix-up pass when a frame leaves the LRU list (pin hit on an unpinned frame, or
// eviction), then commit. Both passes walk the frame RAM one frame per cycle on its
// single read port. One request is in flight at a time; the next is taken
// while the response still waits. A stalled response holds the commit step.
// Reset clears valid bits, LRU length and control; no clearing pass.
module buffer_pool_lru_pin_manager #(
	parameter int NUM_FRAMES = bplm_pkg::NUM_FRAMES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bplm_req_if.sink   req,
	bplm_rsp_if.source rsp
);
	import bplm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic req_ready;
	logic rsp_valid;

	bplm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bplm_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_op         (req.op),
		.req_block_id   (req.block_id),
		.req_mark_dirty (req.mark_dirty),
		.rsp_status     (rsp.status),
		.rsp_frame      (rsp.frame),
		.rsp_writeback  (rsp.writeback),
		.rsp_old_block  (rsp.old_block),
		.rsp_pins_after (rsp.pins_after)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

endmodule

@@ design/bplm_chk.sv @@
module bplm_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [bplm_pkg::STAT_W-1:0]   rsp_status,
	input logic [bplm_pkg::FRAME_W-1:0]  rsp_frame,
	input logic                          rsp_writeback,
	input logic [bplm_pkg::BLK_W-1:0]    rsp_old_block,
	input logic [bplm_pkg::PIN_W-1:0]    rsp_pins_after
);
	import bplm_pkg::*;

	// A stalled response keeps its status, frame, pin count and old block
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_frame)
			&& $stable(rsp_pins_after) && $stable(rsp_old_block))
		else $error("response changed while stalled");

	// Eviction fields only carry data on an eviction
	a_evict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_EVICT) |-> !rsp_writeback && (rsp_old_block == '0))
		else $error("writeback or old block set outside eviction");

	// Failed lookups report frame and pin count zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_status == ST_NOFRAME) || (rsp_status == ST_NOTRES))
			|-> (rsp_frame == '0) && (rsp_pins_after == '0))
		else $error("failed request reports a frame");

	// A freshly loaded frame holds exactly one pin
	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_status == ST_LOAD) || (rsp_status == ST_EVICT))
			|-> (rsp_pins_after == PIN_W'(1)))
		else $error("loaded frame pin count not one");

	// A hit always leaves the frame pinned
	a_hit_pinned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_HIT) |-> (rsp_pins_after != '0))
		else $error("hit leaves frame unpinned");

endmodule

bind buffer_pool_lru_pin_manager bplm_chk u_bplm_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_frame      (rsp.frame),
	.rsp_writeback  (rsp.writeback),
	.rsp_old_block  (rsp.old_block),
	.rsp_pins_after (rsp.pins_after)
);

@@ sim/buffer_pool_lru_pin_manager_checker.sv @@
module buffer_pool_lru_pin_manager_checker (
	input logic  clk,
	input logic  arst_n,
	bplm_req_if  req,
	bplm_rsp_if  rsp,
	output int   fails,
	output int   pending,
	output int   n_checked,
	output int   n_hits,
	output int   n_evicts,
	output int   n_writebacks,
	output int   n_noframe,
	output int   n_ceiling
);
	import bplm_pkg::*;

	localparam int NFR = NUM_FRAMES_DEF;

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] frame;
		logic               writeback;
		logic [BLK_W-1:0]   old_block;
		logic [PIN_W-1:0]   pins_after;
	} outcome_t;

	// Shadow frame table
	logic [BLK_W-1:0] held_blk [NFR];
	logic             held_vld [NFR];
	logic [PIN_W-1:0] pin_cnt  [NFR];
	logic             is_dirty [NFR];
	logic [3:0]       lru_age  [NFR];
	logic [4:0]       lru_len;

	outcome_t due_rsp [$];
	outcome_t want;

	function automatic bit on_lru(int f);
		return held_vld[f] && (pin_cnt[f] == '0);
	endfunction

	// Take a frame off the LRU list; younger frames move up one place
	function automatic void drop_from_lru(int f);
		for (int g = 0; g < NFR; g++) begin
			if (g != f && on_lru(g) && lru_age[g] > lru_age[f])
				lru_age[g]--;
		end
		if (lru_len != 0)
			lru_len--;
	endfunction

	// Apply one request to the shadow table and return the response it must give
	function automatic outcome_t frame_table_step(logic op, logic [BLK_W-1:0] blk, logic md);
		int hit;
		int spare;
		int oldest;
		outcome_t o;
		hit = -1;
		spare = -1;
		oldest = -1;
		o = '0;
		for (int f = NFR - 1; f >= 0; f--) begin
			if (held_vld[f] && held_blk[f] == blk)
				hit = f;
			if (!held_vld[f])
				spare = f;
			if (on_lru(f) && lru_age[f] == '0)
				oldest = f;
		end
		if (op == OP_PIN) begin
			if (hit >= 0) begin
				if (pin_cnt[hit] == '0)
					drop_from_lru(hit);
				if (pin_cnt[hit] != '1)
					pin_cnt[hit]++;
				o.status = ST_HIT;
				o.frame = FRAME_W'(hit);
				o.pins_after = pin_cnt[hit];
			end else if (spare >= 0) begin
				held_vld[spare] = 1'b1;
				held_blk[spare] = blk;
				is_dirty[spare] = 1'b0;
				pin_cnt[spare] = 8'd1;
				o.status = ST_LOAD;
				o.frame = FRAME_W'(spare);
				o.pins_after = 8'd1;
			end else if (oldest < 0) begin
				o.status = ST_NOFRAME;
			end else begin
				o.status = ST_EVICT;
				o.frame = FRAME_W'(oldest);
				o.writeback = is_dirty[oldest];
				o.old_block = held_blk[oldest];
				o.pins_after = 8'd1;
				drop_from_lru(oldest);
				is_dirty[oldest] = 1'b0;
				held_blk[oldest] = blk;
				pin_cnt[oldest] = 8'd1;
			end
		end else if (hit < 0) begin
			o.status = ST_NOTRES;
		end else if (pin_cnt[hit] == '0) begin
			// already unpinned: flag only, LRU place kept
			o.status = ST_NOTPIN;
			o.frame = FRAME_W'(hit);
		end else begin
			if (md)
				is_dirty[hit] = 1'b1;
			pin_cnt[hit]--;
			if (pin_cnt[hit] == '0) begin
				lru_age[hit] = lru_len[3:0];
				lru_len++;
			end
			o.status = ST_UNPIN;
			o.frame = FRAME_W'(hit);
			o.pins_after = pin_cnt[hit];
		end
		return o;
	endfunction

	// Responses are checked before the request of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < NFR; f++) begin
				held_blk[f] = '0;
				held_vld[f] = 1'b0;
				pin_cnt[f] = '0;
				is_dirty[f] = 1'b0;
				lru_age[f] = '0;
			end
			lru_len = '0;
			due_rsp.delete();
			fails = 0;
			pending = 0;
			n_checked = 0;
			n_hits = 0;
			n_evicts = 0;
			n_writebacks = 0;
			n_noframe = 0;
			n_ceiling = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_rsp.size() == 0) begin
					$error("response with no request outstanding (status %0d frame %0d)",
						rsp.status, rsp.frame);
					fails++;
				end else begin
					want = due_rsp.pop_front();
					n_checked++;
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fails++;
					end
					if (rsp.frame !== want.frame) begin
						$error("frame: expected %0d, got %0d", want.frame, rsp.frame);
						fails++;
					end
					if (rsp.writeback !== want.writeback) begin
						$error("writeback: expected %0d, got %0d", want.writeback,
							rsp.writeback);
						fails++;
					end
					if (rsp.old_block !== want.old_block) begin
						$error("old_block: expected %h, got %h", want.old_block,
							rsp.old_block);
						fails++;
					end
					if (rsp.pins_after !== want.pins_after) begin
						$error("pins_after: expected %0d, got %0d", want.pins_after,
							rsp.pins_after);
						fails++;
					end
				end
			end
			if (req.valid && req.ready) begin
				want = frame_table_step(req.op, req.block_id, req.mark_dirty);
				due_rsp.push_back(want);
				case (want.status)
					ST_HIT: begin
						n_hits++;
						if (want.pins_after == '1)
							n_ceiling++;
					end
					ST_EVICT: begin
						n_evicts++;
						if (want.writeback)
							n_writebacks++;
					end
					ST_NOFRAME: n_noframe++;
					default: ;
				endcase
			end
			pending = due_rsp.size();
		end
	end

endmodule

@@ sim/buffer_pool_lru_pin_manager_test.sv @@
module buffer_pool_lru_pin_manager_test;
	import bplm_pkg::*;

	localparam int POOL_SZ = 40;

	logic clk;
	logic arst_n;

	int fails;
	int pending;
	int n_checked;
	int n_hits;
	int n_evicts;
	int n_writebacks;
	int n_noframe;
	int n_ceiling;

	int idle_pct;
	int stall_pct;

	logic [BLK_W-1:0] pool [POOL_SZ];
	logic [BLK_W-1:0] pinned_ids [$];

	bplm_req_if req_ch ();
	bplm_rsp_if rsp_ch ();

	buffer_pool_lru_pin_manager dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	buffer_pool_lru_pin_manager_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fails        (fails),
		.pending      (pending),
		.n_checked    (n_checked),
		.n_hits       (n_hits),
		.n_evicts     (n_evicts),
		.n_writebacks (n_writebacks),
		.n_noframe    (n_noframe),
		.n_ceiling    (n_ceiling)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Response back-pressure, redrawn every cycle
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Present one request at a falling edge and hold it until taken
	task automatic send_req(input logic op, input logic [BLK_W-1:0] blk, input logic md);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.block_id <= blk;
		req_ch.mark_dirty <= md;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Pin and unpin keep a rough list of blocks the stimulus holds pinned
	task automatic pin_block(input logic [BLK_W-1:0] blk);
		pinned_ids.push_back(blk);
		send_req(OP_PIN, blk, 1'($urandom_range(1)));
	endtask

	task automatic unpin_block(input logic [BLK_W-1:0] blk, input logic md);
		int idx;
		idx = -1;
		for (int i = pinned_ids.size() - 1; i >= 0; i--) begin
			if (pinned_ids[i] == blk)
				idx = i;
		end
		if (idx >= 0)
			pinned_ids.delete(idx);
		send_req(OP_UNPIN, blk, md);
	endtask

	// One random request: mostly balanced pin/unpin traffic over a small pool
	task automatic random_req();
		int roll;
		int idx;
		logic [BLK_W-1:0] blk;
		roll = $urandom_range(99);
		if (pinned_ids.size() >= 20 || (pinned_ids.size() > 4 && roll < 42)) begin
			idx = $urandom_range(pinned_ids.size() - 1);
			blk = pinned_ids[idx];
			unpin_block(blk, 1'($urandom_range(1)));
		end else if (roll < 90) begin
			pin_block(pool[$urandom_range(POOL_SZ - 1)]);
		end else if (roll < 95) begin
			unpin_block(pool[$urandom_range(POOL_SZ - 1)], 1'($urandom_range(1)));
		end else begin
			send_req(1'($urandom_range(1)), BLK_W'($urandom), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		#10_000_000;
		$display("buffer_pool_lru_pin_manager verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PIN;
		req_ch.block_id = '0;
		req_ch.mark_dirty = 1'b0;
		rsp_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_SZ; i++)
			pool[i] = BLK_W'($urandom);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: fill every frame, then exhaust, misses and LRU eviction
		for (int i = 0; i < 16; i++)
			pin_block(pool[i]);
		pin_block(pool[16]);                 // all frames pinned: no frame
		unpin_block(24'h5A5A5A, 1'b1);       // block not resident
		unpin_block(pool[1], 1'b1);          // dirty, becomes least recent
		unpin_block(pool[1], 1'b1);          // already unpinned
		pin_block(pool[0]);                  // hit, count goes to two
		unpin_block(pool[2], 1'b0);          // clean, second on the list
		pin_block(pool[17]);                 // evicts the dirty frame
		pin_block(pool[18]);                 // evicts the clean frame
		unpin_block(pool[0], 1'b0);
		unpin_block(pool[0], 1'b1);

		// Random traffic in four back-pressure phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 79; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 79; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			for (int n = 0; n < 330; n++) begin
				// one burst drives a pin count into its ceiling
				if (ph == 2 && n == 200) begin
					for (int k = 0; k < 258; k++)
						pin_block(pool[5]);
				end
				random_req();
			end
		end
		req_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("checked %0d responses: %0d hits (%0d at the pin ceiling), %0d evictions",
			n_checked, n_hits, n_ceiling, n_evicts);
		$display("  %0d evictions wrote back a dirty frame, %0d pins found no frame",
			n_writebacks, n_noframe);
		if (fails == 0) begin
			$display("buffer_pool_lru_pin_manager verification clean");
		end else begin
			$display("buffer_pool_lru_pin_manager verification failed");
		end
		$finish;
	end

endmodule
